// File: sv/rpbc_pkg.sv
`default_nettype none
package rpbc_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_PULSE_MIN   = 3'd0,
		REG_PULSE_SPAN  = 3'd1,
		REG_REVERSE_DIR = 3'd2,
		REG_LOW_THRESH  = 3'd3,
		REG_HIGH_THRESH = 3'd4,
		REG_HYST_MARGIN = 3'd5
	} rpbc_reg_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	// register values after reset
	localparam logic [15:0] RST_PULSE_MIN   = 16'd77;
	localparam logic [15:0] RST_PULSE_SPAN  = 16'd31;
	localparam logic        RST_REVERSE_DIR = 1'b1;
	localparam logic [15:0] RST_LOW_THRESH  = 16'd5;
	localparam logic [15:0] RST_HIGH_THRESH = 16'd26;
	localparam logic [7:0]  RST_HYST_MARGIN = 8'd1;

	// band time stops following the coarse counter above this value
	localparam logic [7:0] ELAPSED_LIMIT = 8'd254;

	typedef enum logic [1:0] {
		BAND_LOW  = 2'd0,
		BAND_MID  = 2'd1,
		BAND_HIGH = 2'd2
	} rpbc_band_t;

	typedef struct packed {
		logic [15:0] pulse_min;
		logic [15:0] pulse_span;
		logic        reverse_dir;
		logic [15:0] low_threshold;
		logic [15:0] high_threshold;
		logic [7:0]  hysteresis_margin;
	} rpbc_cfg_t;

	// one tick after edge timing: measured width and coarse time of the tick
	typedef struct packed {
		logic [15:0] raw_width;
		logic [7:0]  coarse;
	} rpbc_item_t;

	typedef struct packed {
		logic [15:0] pulse_width;
		logic [15:0] position;
		rpbc_band_t  band;
		logic [7:0]  band_time;
	} rpbc_result_t;

endpackage
`default_nettype wire

// File: sv/rpbc_edge.sv
`default_nettype none
// Edge timing stage: tick and coarse counters, rise stamp and width capture.
module rpbc_edge #(
	parameter int unsigned COARSE_SHIFT = 13
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  wire                  pin_level,
	input  wire                  take,
	output logic                 valid_s1,
	output rpbc_pkg::rpbc_item_t item_s1
);
	import rpbc_pkg::*;

	logic        prev_q;
	logic [15:0] tick_q;
	logic [15:0] rise_q;
	logic [15:0] width_q;
	logic [7:0]  coarse_q;

	logic        rise, fall;
	logic [15:0] width_nxt;
	logic        coarse_tick;

	assign rise        = !prev_q && pin_level;
	assign fall        = prev_q && !pin_level;
	assign width_nxt   = fall ? (tick_q - rise_q) : width_q;
	assign coarse_tick = (tick_q[COARSE_SHIFT-1:0] == '0);

	// timing state, advances once per accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b0;
			tick_q   <= '0;
			rise_q   <= '0;
			width_q  <= '0;
			coarse_q <= '0;
		end else if (accept) begin
			prev_q  <= pin_level;
			tick_q  <= tick_q + 16'd1;
			width_q <= width_nxt;
			if (rise) begin
				rise_q <= tick_q;
			end
			if (coarse_tick) begin
				coarse_q <= coarse_q + 8'd1;
			end
		end
	end

	// stage register towards the classifier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.raw_width <= width_nxt;
			item_s1.coarse    <= coarse_q;
		end
	end

endmodule
`default_nettype wire

// File: sv/rpbc_band.sv
`default_nettype none
// Position normalising and band classification with hysteresis.
module rpbc_band (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    commit,
	input  rpbc_pkg::rpbc_item_t   item,
	input  rpbc_pkg::rpbc_cfg_t    cfg,
	output rpbc_pkg::rpbc_result_t res
);
	import rpbc_pkg::*;

	rpbc_band_t  band_q;
	logic [7:0]  start_q;
	logic [7:0]  elapsed_q;

	logic [16:0] hi_bound;
	logic [15:0] clamped;
	logic [15:0] offset;
	logic [15:0] pos;

	logic signed [17:0] p_s, lt_s, ht_s, m_s;
	logic        a1, a2, c1, c2, not_low, not_high, change;
	rpbc_band_t  band_nxt;
	logic [7:0]  elapsed_nxt;

	// clamp to [min, min+span], remove offset, optional mirror
	always_comb begin
		hi_bound = {1'b0, cfg.pulse_min} + {1'b0, cfg.pulse_span};
		clamped  = item.raw_width;
		if (item.raw_width < cfg.pulse_min) begin
			clamped = cfg.pulse_min;
		end else if ({1'b0, item.raw_width} > hi_bound) begin
			clamped = hi_bound[15:0];
		end
		offset = clamped - cfg.pulse_min;
		pos    = cfg.reverse_dir ? (cfg.pulse_span - offset) : offset;
	end

	// signed threshold compares, wide enough not to overflow
	always_comb begin
		p_s      = signed'({2'b00, pos});
		lt_s     = signed'({2'b00, cfg.low_threshold});
		ht_s     = signed'({2'b00, cfg.high_threshold});
		m_s      = signed'({10'd0, cfg.hysteresis_margin});
		a1       = p_s <= (lt_s - m_s);
		a2       = p_s >= (lt_s + m_s);
		c1       = p_s >= (ht_s + m_s);
		c2       = p_s <= (ht_s - m_s);
		not_low  = (band_q != BAND_LOW);
		not_high = (band_q != BAND_HIGH);
		change   = (a1 && not_low) || (c1 && not_high) ||
		           (a2 && c2 && !(not_low && not_high));
	end

	// next band and band time; low test wins over high
	always_comb begin
		band_nxt    = band_q;
		elapsed_nxt = elapsed_q;
		priority if (change) begin
			priority if (a1) begin
				band_nxt = BAND_LOW;
			end else if (c1) begin
				band_nxt = BAND_HIGH;
			end else begin
				band_nxt = BAND_MID;
			end
			elapsed_nxt = '0;
		end else if (elapsed_q <= ELAPSED_LIMIT) begin
			elapsed_nxt = item.coarse - start_q;
		end else begin
			// band time frozen
			elapsed_nxt = elapsed_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q    <= BAND_MID;
			start_q   <= '0;
			elapsed_q <= '0;
		end else if (commit) begin
			band_q    <= band_nxt;
			elapsed_q <= elapsed_nxt;
			if (change) begin
				start_q <= item.coarse;
			end
		end
	end

	assign res.pulse_width = item.raw_width;
	assign res.position    = pos;
	assign res.band        = band_nxt;
	assign res.band_time   = elapsed_nxt;

endmodule
`default_nettype wire

// File: sv/rc_pulse_band_classifier.sv
`default_nettype none
// RC pulse band classifier. Takes one pin sample per timer tick and returns one
// result per sample: the last measured high-pulse width, the clamped, offset and
// optionally mirrored position, the band (low, middle, high) and the coarse
// ticks spent in that band. A sample may be accepted every clock cycle unless
// in_stall is high, and each result passes through the edge stage register and
// then the output register. The edge timing stage is one register. The position
// and band logic sits between that register and the output register. While a
// result is stalled at the output, one further sample can still be taken into
// the edge stage, and the input stalls only when both registers are full.
// Configuration writes are always ready and take effect at once, so they should
// only be made while no samples are in flight.
module rc_pulse_band_classifier #(
	parameter int unsigned COARSE_SHIFT = 13
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire                               pin_level,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic [15:0]                       pulse_width,
	output logic [15:0]                       position,
	output logic [1:0]                        band,
	output logic [7:0]                        band_time,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [rpbc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire  [rpbc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import rpbc_pkg::*;

	rpbc_cfg_t    cfg_q;
	rpbc_item_t   item_s1;
	rpbc_result_t res;
	rpbc_result_t out_s2;
	logic         valid_s1;
	logic         advance;
	logic         take;
	logic         accept;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_min         <= RST_PULSE_MIN;
			cfg_q.pulse_span        <= RST_PULSE_SPAN;
			cfg_q.reverse_dir       <= RST_REVERSE_DIR;
			cfg_q.low_threshold     <= RST_LOW_THRESH;
			cfg_q.high_threshold    <= RST_HIGH_THRESH;
			cfg_q.hysteresis_margin <= RST_HYST_MARGIN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (rpbc_reg_t'(cfg_index))
				REG_PULSE_MIN:   cfg_q.pulse_min         <= cfg_data;
				REG_PULSE_SPAN:  cfg_q.pulse_span        <= cfg_data;
				REG_REVERSE_DIR: cfg_q.reverse_dir       <= cfg_data[0];
				REG_LOW_THRESH:  cfg_q.low_threshold     <= cfg_data;
				REG_HIGH_THRESH: cfg_q.high_threshold    <= cfg_data;
				REG_HYST_MARGIN: cfg_q.hysteresis_margin <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign advance  = !out_valid || !out_stall;
	assign take     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	rpbc_edge #(
		.COARSE_SHIFT(COARSE_SHIFT)
	) u_edge (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.pin_level(pin_level),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rpbc_band u_band (
		.clk   (clk),
		.arst_n(arst_n),
		.commit(take),
		.item  (item_s1),
		.cfg   (cfg_q),
		.res   (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_s2 <= res;
		end
	end

	assign pulse_width = out_s2.pulse_width;
	assign position    = out_s2.position;
	assign band        = out_s2.band;
	assign band_time   = out_s2.band_time;

endmodule
`default_nettype wire

// File: sv/rpbc_checker.sv
`default_nettype none
// Port-level checks for the classifier.
module rpbc_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              in_valid,
	input wire                              in_stall,
	input wire                              out_valid,
	input wire                              out_stall,
	input wire [15:0]                       pulse_width,
	input wire [15:0]                       position,
	input wire [1:0]                        band,
	input wire [7:0]                        band_time,
	input wire                              cfg_valid,
	input wire                              cfg_ready
);
	import rpbc_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pulse_width) &&
		$stable(position) && $stable(band) && $stable(band_time))
		else $error("stalled result changed");

	// every accepted sample has a result waiting after the edge stage and output registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid)
		else $error("result missing after accepted sample");

	// only the three defined bands are shown
	a_band_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (band == BAND_LOW) || (band == BAND_MID) || (band == BAND_HIGH))
		else $error("undefined band code");

	// configuration port never pushes back
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write not taken");

endmodule

bind rc_pulse_band_classifier rpbc_checker u_rpbc_checker (.*);
`default_nettype wire

// File: verif/rc_pulse_band_classifier_test.sv
`timescale 1ns / 1ps

module rc_pulse_band_classifier_test;
	import rpbc_pkg::*;

	localparam int COARSE_SHIFT = 13;
	localparam int CYCLE_LIMIT  = 1200000;
	localparam int SETTLE       = 8;
	localparam int PHASE_ITEMS  = 140;
	localparam int RAND_PHASES  = 7;

	typedef enum logic {
		ROW_SAMPLE,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		rpbc_reg_t    idx;
		logic [15:0]  data;
		logic         pin;
		logic         typed;
		rpbc_result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic pin_level;
	logic out_valid;
	logic out_stall;
	logic [15:0] pulse_width;
	logic [15:0] position;
	logic [1:0] band;
	logic [7:0] band_time;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rc_pulse_band_classifier #(
		.COARSE_SHIFT(COARSE_SHIFT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pin_level(pin_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pulse_width(pulse_width),
		.position(position),
		.band(band),
		.band_time(band_time),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state: register copy and decoder state
	rpbc_cfg_t   shadow_cfg;
	logic        last_level;
	logic [15:0] tick_now;
	logic [15:0] rise_tick;
	logic [15:0] held_width;
	logic [7:0]  coarse_now;
	rpbc_band_t  band_now;
	logic [7:0]  band_from;
	logic [7:0]  band_age;

	rpbc_result_t pending_results[$];
	stim_row_t    stim_rows[$];

	int  faults;
	int  cycle_count;
	int  samples_sent;
	int  results_seen;
	int  reg_writes;
	int  settings_used;
	int  band_hits[3];
	int  oldest_band_time;
	bit  idle_on;
	int  stall_left;
	bit  took_result;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("** rc_pulse_band_classifier: FAILED **");
			$finish;
		end
	end

	function automatic int pick_wait();
		if (!idle_on)
			return 0;
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic void note_fault(input string msg);
		faults++;
		if (faults <= 10)
			$display("%s", msg);
	endfunction

	// one tick of the decoder: edge timing, clamp, band with hysteresis, counters
	function automatic rpbc_result_t next_reading(input logic level);
		logic [16:0] lo_b;
		logic [16:0] hi_b;
		logic [16:0] v;
		int p;
		int lt;
		int ht;
		int mg;
		logic a1;
		logic a2;
		logic c1;
		logic c2;
		logic not_low;
		logic not_high;
		rpbc_result_t r;
		if (!last_level && level)
			rise_tick = tick_now;
		else if (last_level && !level)
			held_width = tick_now - rise_tick;
		last_level = level;

		lo_b = {1'b0, shadow_cfg.pulse_min};
		hi_b = lo_b + {1'b0, shadow_cfg.pulse_span};
		v = {1'b0, held_width};
		if (v < lo_b)
			v = lo_b;
		if (v > hi_b)
			v = hi_b;
		v = v - lo_b;
		if (shadow_cfg.reverse_dir)
			v = {1'b0, shadow_cfg.pulse_span} - v;

		p  = int'(v[15:0]);
		lt = int'(shadow_cfg.low_threshold);
		ht = int'(shadow_cfg.high_threshold);
		mg = int'(shadow_cfg.hysteresis_margin);
		a1 = (p <= lt - mg);
		a2 = (p >= lt + mg);
		c1 = (p >= ht + mg);
		c2 = (p <= ht - mg);
		not_low  = (band_now != BAND_LOW);
		not_high = (band_now != BAND_HIGH);

		// low test wins over high test, even with crossed thresholds
		if ((a1 && not_low) || (c1 && not_high) || (a2 && c2 && !(not_low && not_high))) begin
			if (a1)
				band_now = BAND_LOW;
			else if (c1)
				band_now = BAND_HIGH;
			else
				band_now = BAND_MID;
			band_from = coarse_now;
			band_age = 8'd0;
		end else if (band_age <= ELAPSED_LIMIT) begin
			band_age = coarse_now - band_from;
		end

		if (tick_now[COARSE_SHIFT-1:0] == '0)
			coarse_now = coarse_now + 8'd1;
		tick_now = tick_now + 16'd1;

		r.pulse_width = held_width;
		r.position    = v[15:0];
		r.band        = band_now;
		r.band_time   = band_age;
		return r;
	endfunction

	// one sample transfer; the typed expectation, if given, replaces the prediction
	task automatic send_sample(input logic level, input bit typed, input rpbc_result_t want);
		int gap;
		rpbc_result_t r;
		gap = pick_wait();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		pin_level <= level;
		do @(posedge clk); while (in_stall);
		r = next_reading(level);
		pending_results.push_back(typed ? want : r);
		samples_sent++;
	endtask

	task automatic send_pulse(input int hi_len, input int lo_len);
		repeat (hi_len) send_sample(1'b1, 1'b0, '0);
		repeat (lo_len) send_sample(1'b0, 1'b0, '0);
	endtask

	// stop sending and let every outstanding result come out
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input rpbc_reg_t idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PULSE_MIN:   shadow_cfg.pulse_min = data;
			REG_PULSE_SPAN:  shadow_cfg.pulse_span = data;
			REG_REVERSE_DIR: shadow_cfg.reverse_dir = data[0];
			REG_LOW_THRESH:  shadow_cfg.low_threshold = data;
			REG_HIGH_THRESH: shadow_cfg.high_threshold = data;
			REG_HYST_MARGIN: shadow_cfg.hysteresis_margin = data[7:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// style 0: small widths, 1: full 16-bit values, 2: long pulses
	task automatic pick_settings(input int style);
		logic [15:0] mn;
		logic [15:0] sp;
		logic [15:0] lt;
		logic [15:0] ht;
		logic [15:0] tmp;
		logic [15:0] mg;
		logic [15:0] rv;
		rv = 16'($urandom);
		if (style == 1) begin
			mn = 16'($urandom);
			sp = 16'($urandom);
			lt = 16'($urandom);
			ht = 16'($urandom);
			mg = 16'($urandom);
		end else if (style == 2) begin
			mn = 16'd300;
			sp = 16'd120;
			lt = 16'd30;
			ht = 16'd90;
			mg = {8'($urandom), 8'd20};
		end else begin
			mn = 16'($urandom_range(0, 40));
			sp = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 40));
			lt = 16'($urandom_range(0, sp + 2));
			ht = 16'($urandom_range(lt, sp + 4));
			if ($urandom_range(0, 4) == 0) begin
				tmp = lt;
				lt = ht;
				ht = tmp;
			end
			mg = {8'($urandom), 8'($urandom_range(0, 4))};
		end
		write_reg(REG_PULSE_MIN, mn);
		write_reg(REG_PULSE_SPAN, sp);
		write_reg(REG_REVERSE_DIR, rv);
		write_reg(REG_LOW_THRESH, lt);
		write_reg(REG_HIGH_THRESH, ht);
		write_reg(REG_HYST_MARGIN, mg);
		settings_used++;
	endtask

	// random pulse trains: mostly clean pulses round the clamp window, some noise
	task automatic run_phase(input int count);
		int first;
		int pause_at;
		int lo_b;
		int hi_b;
		bit paused;
		first = samples_sent;
		pause_at = $urandom_range(20, count - 20);
		paused = 1'b0;
		while (samples_sent - first < count) begin
			if (!paused && samples_sent - first >= pause_at) begin
				drain_results();
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) < 8) begin
				lo_b = (shadow_cfg.pulse_min > 3) ? int'(shadow_cfg.pulse_min) - 3 : 1;
				hi_b = int'(shadow_cfg.pulse_min) + int'(shadow_cfg.pulse_span) + 3;
				if (lo_b > 200) begin
					lo_b = 1;
					hi_b = 60;
				end else if (hi_b > 200) begin
					hi_b = 200;
				end
				send_pulse($urandom_range(lo_b, hi_b), $urandom_range(1, 12));
			end else begin
				repeat ($urandom_range(1, 8))
					send_sample(1'($urandom), 1'b0, '0);
			end
		end
	endtask

	task automatic row_s(input logic pin);
		stim_rows.push_back('{ROW_SAMPLE, REG_PULSE_MIN, 16'd0, pin, 1'b0, '0});
	endtask

	task automatic row_sx(input logic pin, input rpbc_result_t want);
		stim_rows.push_back('{ROW_SAMPLE, REG_PULSE_MIN, 16'd0, pin, 1'b1, want});
	endtask

	task automatic row_w(input rpbc_reg_t idx, input logic [15:0] data);
		stim_rows.push_back('{ROW_WRITE, idx, data, 1'b0, 1'b0, '0});
	endtask

	// output side: random stall per result
	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			took_result = arst_n && out_valid && !out_stall;
			@(negedge clk);
			if (took_result)
				stall_left = pick_wait();
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		rpbc_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				note_fault($sformatf("result with nothing expected: width %0d position %0d band %0d time %0d",
					pulse_width, position, band, band_time));
			end else begin
				exp_r = pending_results.pop_front();
				if (exp_r.pulse_width !== pulse_width || exp_r.position !== position ||
						exp_r.band !== band || exp_r.band_time !== band_time)
					note_fault($sformatf(
						"result %0d mismatch (exp/got): width %0d/%0d position %0d/%0d band %0d/%0d time %0d/%0d",
						results_seen, exp_r.pulse_width, pulse_width, exp_r.position, position,
						exp_r.band, band, exp_r.band_time, band_time));
			end
			if (band < 2'd3)
				band_hits[band]++;
			if (int'(band_time) > oldest_band_time)
				oldest_band_time = int'(band_time);
		end
	end

	// stimulus
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		pin_level = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_PULSE_MIN;
		cfg_data  = '0;
		faults = 0;
		samples_sent = 0;
		results_seen = 0;
		reg_writes = 0;
		settings_used = 1;
		oldest_band_time = 0;
		band_hits = '{0, 0, 0};
		idle_on = 1'b1;

		shadow_cfg.pulse_min         = RST_PULSE_MIN;
		shadow_cfg.pulse_span        = RST_PULSE_SPAN;
		shadow_cfg.reverse_dir       = RST_REVERSE_DIR;
		shadow_cfg.low_threshold     = RST_LOW_THRESH;
		shadow_cfg.high_threshold    = RST_HIGH_THRESH;
		shadow_cfg.hysteresis_margin = RST_HYST_MARGIN;
		last_level = 1'b0;
		tick_now   = '0;
		rise_tick  = '0;
		held_width = '0;
		coarse_now = '0;
		band_now   = BAND_MID;
		band_from  = '0;
		band_age   = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset values, short pulse below the window
		row_sx(1'b0, '{16'd0, 16'd31, BAND_HIGH, 8'd0});
		row_s(1'b1);
		row_s(1'b1);
		row_s(1'b0);
		// zero span pins the position to zero
		row_w(REG_PULSE_MIN, 16'd0);
		row_w(REG_PULSE_SPAN, 16'd0);
		row_w(REG_REVERSE_DIR, 16'd0);
		row_s(1'b1);
		row_sx(1'b0, '{16'd1, 16'd0, BAND_LOW, 8'd0});
		// largest window, mirrored; upper data bits of the direction bit ignored
		row_w(REG_PULSE_MIN, 16'hFFFF);
		row_w(REG_PULSE_SPAN, 16'hFFFF);
		row_w(REG_REVERSE_DIR, 16'hFFFF);
		row_s(1'b1);
		row_sx(1'b0, '{16'd1, 16'hFFFF, BAND_HIGH, 8'd0});
		row_w(REG_LOW_THRESH, 16'hFFFF);
		row_w(REG_HIGH_THRESH, 16'hFFFF);
		row_w(REG_HYST_MARGIN, 16'd255);
		row_s(1'b0);
		// zero margin on a boundary: band re-entered, low test first
		row_w(REG_REVERSE_DIR, 16'd0);
		row_w(REG_LOW_THRESH, 16'd0);
		row_w(REG_HIGH_THRESH, 16'd0);
		row_w(REG_HYST_MARGIN, 16'hFF00);
		row_sx(1'b0, '{16'd1, 16'd0, BAND_LOW, 8'd0});
		row_sx(1'b0, '{16'd1, 16'd0, BAND_LOW, 8'd0});
		// small window: widths below and inside
		row_w(REG_PULSE_MIN, 16'd2);
		row_w(REG_PULSE_SPAN, 16'd6);
		row_w(REG_LOW_THRESH, 16'd2);
		row_w(REG_HIGH_THRESH, 16'd4);
		row_w(REG_HYST_MARGIN, 16'd1);
		row_s(1'b1);
		row_s(1'b0);
		row_s(1'b1);
		row_s(1'b1);
		row_s(1'b1);
		row_s(1'b1);
		row_s(1'b0);
		// crossed thresholds
		row_w(REG_LOW_THRESH, 16'd6);
		row_w(REG_HIGH_THRESH, 16'd1);
		row_w(REG_HYST_MARGIN, 16'd0);
		row_s(1'b0);
		row_s(1'b0);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_WRITE) begin
				drain_results();
				write_reg(stim_rows[i].idx, stim_rows[i].data);
			end else begin
				send_sample(stim_rows[i].pin, stim_rows[i].typed, stim_rows[i].want);
			end
		end

		// random phases, one of them without idling and one with full-width registers
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain_results();
			pick_settings((ph == 3) ? 1 : 0);
			idle_on = (ph != 1);
			run_phase(PHASE_ITEMS);
		end

		// one long pulse in a wide window, then short ones below it
		drain_results();
		pick_settings(2);
		idle_on = 1'b0;
		send_pulse($urandom_range(280, 440), $urandom_range(1, 12));
		idle_on = 1'b1;
		for (int k = 0; k < 6; k++)
			send_pulse($urandom_range(1, 40), $urandom_range(1, 12));

		drain_results();
		$display("run covered %0d samples under %0d register settings (%0d writes), %0d results checked",
			samples_sent, settings_used, reg_writes, results_seen);
		$display("bands seen: low %0d, middle %0d, high %0d; longest band time %0d",
			band_hits[0], band_hits[1], band_hits[2], oldest_band_time);
		if (faults == 0) begin
			$display("** rc_pulse_band_classifier: PASSED **");
		end else begin
			$display("%0d mismatches in total", faults);
			$display("** rc_pulse_band_classifier: FAILED **");
		end
		$finish;
	end

endmodule
